// ===== rtl/i2c_baud_divider_calc_macros.svh =====
// Assertion macros for the I2C baud divider calculator.
// Included by the RTL files that assert; expects clk and rst in scope.
`ifndef I2C_BAUD_DIVIDER_CALC_MACROS_SVH
`define I2C_BAUD_DIVIDER_CALC_MACROS_SVH

// Checked while out of reset
`define I2CBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included
`define I2CBD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/i2cbd_pkg.sv =====
// Package for the I2C baud divider calculator: speed classes, limits,
// reciprocal constants and the radix-2 divide step. No dependencies.
package i2cbd_pkg;

  localparam int CORE_W = 16;
  localparam int DIV_W  = 12;  // targets that pass the range check fit here

  // Speed class limits, kHz
  localparam logic [15:0] RATE_STD_MAX  = 16'd100;
  localparam logic [15:0] RATE_FAST_MAX = 16'd400;
  localparam logic [15:0] RATE_FP_MAX   = 16'd1000;
  localparam logic [15:0] RATE_HS_MAX   = 16'd3400;

  typedef enum logic [1:0] {
    CLS_STD  = 2'd0,
    CLS_FAST = 2'd1,
    CLS_FP   = 2'd2,
    CLS_HS   = 2'd3
  } cls_t;

  // Reciprocals for the rise-time term:
  //   core / 1000     = (core * REC_STD)  >> 26
  //   3*core / 10000  = (3core * REC_FAST) >> 32
  //   3*core / 25000  = (3core * REC_FP)   >> 33
  localparam logic [18:0] REC_STD  = 19'd67109;
  localparam logic [18:0] REC_FAST = 19'd429497;
  localparam logic [18:0] REC_FP   = 19'd343598;

  // rem / 3 = (rem * REC_THIRD) >> 18, exact for 16-bit rem
  localparam logic [16:0] REC_THIRD = 17'd87382;

  localparam logic [6:0]  MIN_BASE_STD = 7'd12;
  localparam logic [6:0]  MIN_BASE_FP  = 7'd13;
  localparam logic [6:0]  MIN_HS       = 7'd5;
  localparam logic [15:0] REM_OFS_LOW  = 16'd10;
  localparam logic [15:0] REM_OFS_HS   = 16'd2;

  typedef struct packed {
    logic [DIV_W-1:0] r;
    logic [3:0]       q;
  } div4_t;

  // Four restoring divide steps; r_in must be below d
  function automatic div4_t div_step4(input logic [DIV_W-1:0] r_in,
                                      input logic [3:0]       bits,
                                      input logic [DIV_W-1:0] d);
    logic [DIV_W:0]   t;
    logic [DIV_W-1:0] r;
    div4_t            res;
    r     = r_in;
    res.q = '0;
    for (int i = 3; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, d}) begin
        t        = t - {1'b0, d};
        res.q[i] = 1'b1;
      end
      r = t[DIV_W-1:0];
    end
    res.r = r;
    return res;
  endfunction

endpackage

// ===== rtl/i2c_baud_divider_calc.sv =====
// I2C SCL baud divider calculator, six-stage pipeline.
// Depends on i2cbd_pkg and i2c_baud_divider_calc_macros.svh.
//
//  channel | signals                                   | role
//  --------+-------------------------------------------+------------------
//  in      | in_valid, in_ready, core_clock_khz,       | one item: clock
//          | target_rate_khz                           | and target rate
//  out     | out_valid, out_ready, success,            | one item: result
//          | high_divisor, low_divisor                 | for each input
//
// One item per cycle when out_ready does not stall the pipeline.
// The 16/12-bit quotient is formed four bits a stage over stages one to four.
// Each stage has its own valid bit and advances when it is empty or the next
// stage moves, so a stall at out_ready fills bubbles before pushing back.
// Synchronous reset clears the valid bits only.
`include "i2c_baud_divider_calc_macros.svh"

module i2c_baud_divider_calc
  import i2cbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] core_clock_khz,
  input  logic [15:0] target_rate_khz,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        success,
  output logic [7:0]  high_divisor,
  output logic [7:0]  low_divisor
);

  // Stage registers
  logic              v1, v2, v3, v4, v5;
  logic [15:0]       core1, core2, core3, core4;
  logic [DIV_W-1:0]  d1, d2, d3, d4;
  cls_t              cls1, cls2, cls3, cls4, cls5;
  logic              bad1, bad2, bad3, bad4;
  logic [36:0]       prod1;
  logic [6:0]        rise3, rise4;
  logic [6:0]        minr4;
  logic [DIV_W-1:0]  r1, r2, r3, r4;
  logic [3:0]        q1;
  logic [7:0]        q2;
  logic [11:0]       q3;
  logic [15:0]       ratio4;
  logic              ok5;
  logic [15:0]       rem5;
  logic [32:0]       prod5;

  // Per-stage advance
  logic a1, a2, a3, a4, a5, a6;
  assign a6 = !out_valid || out_ready;
  assign a5 = !v5 || a6;
  assign a4 = !v4 || a5;
  assign a3 = !v3 || a4;
  assign a2 = !v2 || a3;
  assign a1 = !v1 || a2;
  assign in_ready = a1;

  // Stage 1 input logic: class, range check, rise product, top quotient bits
  cls_t        in_cls;
  logic        in_bad;
  logic [17:0] mul_x;
  logic [18:0] mul_m;
  div4_t       div1;

  always_comb begin
    in_bad = (target_rate_khz == 16'd0) || (target_rate_khz > RATE_HS_MAX);
    if (target_rate_khz <= RATE_STD_MAX)       in_cls = CLS_STD;
    else if (target_rate_khz <= RATE_FAST_MAX) in_cls = CLS_FAST;
    else if (target_rate_khz <= RATE_FP_MAX)   in_cls = CLS_FP;
    else                                       in_cls = CLS_HS;
    mul_x = {2'b00, core_clock_khz} + {1'b0, core_clock_khz, 1'b0};
    unique case (in_cls)
      CLS_STD: begin
        mul_x = {2'b00, core_clock_khz};
        mul_m = REC_STD;
      end
      CLS_FAST: mul_m = REC_FAST;
      CLS_FP:   mul_m = REC_FP;
      default:  mul_m = '0;
    endcase
    div1 = div_step4('0, core_clock_khz[15:12], target_rate_khz[DIV_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (a1) v1 <= in_valid;
    if (a1 && in_valid) begin
      core1 <= core_clock_khz;
      d1    <= target_rate_khz[DIV_W-1:0];
      cls1  <= in_cls;
      bad1  <= in_bad;
      prod1 <= {19'd0, mul_x} * {18'd0, mul_m};
      r1    <= div1.r;
      q1    <= div1.q;
    end
  end

  // Stage 2: rise term from the product, next quotient bits
  logic [6:0] rise2_c;
  div4_t      div2;

  always_comb begin
    case (cls1)
      CLS_STD:  rise2_c = prod1[32:26];
      CLS_FAST: rise2_c = {2'b00, prod1[36:32]};
      CLS_FP:   rise2_c = {4'b0000, prod1[35:33]};
      default:  rise2_c = '0;
    endcase
    div2 = div_step4(r1, core1[11:8], d1);
  end

  logic [6:0] rise2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (a2) v2 <= v1;
    if (a2 && v1) begin
      core2 <= core1;
      d2    <= d1;
      cls2  <= cls1;
      bad2  <= bad1;
      rise2 <= rise2_c;
      r2    <= div2.r;
      q2    <= {q1, div2.q};
    end
  end

  // Stage 3: class minimum, next quotient bits
  div4_t      div3;
  logic [6:0] minr3_c;
  logic [6:0] minr3;

  always_comb begin
    div3 = div_step4(r2, core2[7:4], d2);
    case (cls2)
      CLS_STD, CLS_FAST: minr3_c = MIN_BASE_STD + rise2;
      CLS_FP:            minr3_c = MIN_BASE_FP + rise2;
      default:           minr3_c = MIN_HS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (a3) v3 <= v2;
    if (a3 && v2) begin
      core3 <= core2;
      d3    <= d2;
      cls3  <= cls2;
      bad3  <= bad2;
      rise3 <= rise2;
      minr3 <= minr3_c;
      r3    <= div3.r;
      q3    <= {q2, div3.q};
    end
  end

  // Stage 4: last quotient bits give the ratio
  div4_t div4;
  assign div4 = div_step4(r3, core3[3:0], d3);

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (a4) v4 <= v3;
    if (a4 && v3) begin
      core4  <= core3;
      d4     <= d3;
      cls4   <= cls3;
      bad4   <= bad3;
      rise4  <= rise3;
      minr4  <= minr3;
      r4     <= div4.r;
      ratio4 <= {q3, div4.q};
    end
  end

  // Stage 5: ratio check, remaining count, product for the divide by three
  logic        ok5_c;
  logic [15:0] rem5_c;

  always_comb begin
    ok5_c = !bad4 && (ratio4 >= {9'd0, minr4});
    if (cls4 == CLS_HS) rem5_c = ratio4 - REM_OFS_HS;
    else                rem5_c = ratio4 - REM_OFS_LOW - {9'd0, rise4};
  end

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (a5) v5 <= v4;
    if (a5 && v4) begin
      ok5   <= ok5_c;
      cls5  <= cls4;
      rem5  <= rem5_c;
      prod5 <= {17'd0, rem5_c} * {16'd0, REC_THIRD};
    end
  end

  // Stage 6: split into high and low divisors, output register
  logic [7:0] hi_c, lo_c;

  always_comb begin
    hi_c = '0;
    lo_c = '0;
    if (ok5) begin
      if (cls5 == CLS_STD || cls5 == CLS_FAST) begin
        hi_c = rem5[8:1];
        lo_c = rem5[8:1];
      end else begin
        hi_c = prod5[25:18];
        lo_c = {prod5[24:18], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (a6) out_valid <= v5;
    if (a6 && v5) begin
      success      <= ok5;
      high_divisor <= hi_c;
      low_divisor  <= lo_c;
    end
  end

  // Rebuilt dividend at stage 4 for the quotient check
  logic [27:0] chk_back4;
  logic [27:0] chk_core4;
  assign chk_back4 = {12'd0, ratio4} * {16'd0, d4} + {16'd0, r4};
  assign chk_core4 = {12'd0, core4};

  // Assertions
  `I2CBD_ASSERT(a_fail_zero,
    out_valid && !success |-> high_divisor == 8'd0 && low_divisor == 8'd0,
    "failed item carries nonzero divisors")
  `I2CBD_ASSERT(a_div_exact,
    v4 && !bad4 |-> (r4 < d4) && (chk_back4 == chk_core4),
    "pipelined quotient does not match dividend")
  `I2CBD_ASSERT(a_accept_enters,
    in_valid && in_ready |=> v1,
    "accepted item did not enter stage one")
  `I2CBD_ASSERT_ALWAYS(a_reset_empty,
    $past(rst) |-> !v1 && !out_valid,
    "pipeline not empty after reset")

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the I2C SCL baud divider calculator pipeline.
// Needs i2cbd_pkg and i2c_baud_divider_calc; builds its own divider predictor.
module tb_top;
  import i2cbd_pkg::cls_t;
  import i2cbd_pkg::CLS_STD;
  import i2cbd_pkg::CLS_FAST;
  import i2cbd_pkg::CLS_FP;
  import i2cbd_pkg::CLS_HS;
  import i2cbd_pkg::RATE_STD_MAX;
  import i2cbd_pkg::RATE_FAST_MAX;
  import i2cbd_pkg::RATE_FP_MAX;
  import i2cbd_pkg::RATE_HS_MAX;

  localparam int N_RANDOM    = 1080;
  localparam int IDLE_PCT    = 31;
  localparam int DRAIN_WAIT  = 12;   // a bit over the six-stage latency
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic       ok;
    logic [7:0] hi;
    logic [7:0] lo;
  } baud_res_t;

  typedef struct packed {
    logic [15:0] core;
    logic [15:0] tgt;
    logic        typed;   // expectation written in the row
    baud_res_t   res;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] core_clock_khz;
  logic [15:0] target_rate_khz;
  logic        out_valid;
  logic        out_ready;
  logic        success;
  logic [7:0]  high_divisor;
  logic [7:0]  low_divisor;

  logic        idle_on;
  int          err_cnt;
  baud_res_t   baud_q[$];
  dir_row_t    dir_tbl[$];

  i2c_baud_divider_calc u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .core_clock_khz  (core_clock_khz),
    .target_rate_khz (target_rate_khz),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .success         (success),
    .high_divisor    (high_divisor),
    .low_divisor     (low_divisor)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Expected divisors for one core clock / target rate pair
  function automatic baud_res_t calc_baud(input logic [15:0] core, input logic [15:0] tgt);
    logic [31:0] ratio;
    logic [31:0] rise;
    logic [31:0] min_ratio;
    logic [31:0] rem;
    logic [31:0] quot;
    cls_t        cls;
    baud_res_t   res;
    res = '0;
    if (tgt == 16'd0 || tgt > RATE_HS_MAX) return res;
    if (tgt <= RATE_STD_MAX)       cls = CLS_STD;
    else if (tgt <= RATE_FAST_MAX) cls = CLS_FAST;
    else if (tgt <= RATE_FP_MAX)   cls = CLS_FP;
    else                           cls = CLS_HS;
    ratio = 32'(core) / 32'(tgt);
    case (cls)
      CLS_STD: begin
        rise      = 32'(core) / 32'd1000;
        min_ratio = 32'd12 + rise;
      end
      CLS_FAST: begin
        rise      = (32'(core) * 32'd3) / 32'd10000;
        min_ratio = 32'd12 + rise;
      end
      CLS_FP: begin
        rise      = (32'(core) * 32'd3) / 32'd25000;
        min_ratio = 32'd13 + rise;
      end
      default: begin
        rise      = 32'd0;
        min_ratio = 32'd5;
      end
    endcase
    if (ratio < min_ratio) return res;
    rem = (cls == CLS_HS) ? ratio - 32'd2 : ratio - 32'd10 - rise;
    res.ok = 1'b1;
    if (cls == CLS_STD || cls == CLS_FAST) begin
      quot   = rem / 32'd2;
      res.hi = quot[7:0];
      res.lo = quot[7:0];
    end else begin
      quot   = rem / 32'd3;
      res.hi = quot[7:0];
      res.lo = {quot[6:0], 1'b0};   // doubling of the truncated high value
    end
    return res;
  endfunction

  task automatic add_row(input logic [15:0] core, input logic [15:0] tgt, input logic typed,
                         input logic ok, input logic [7:0] hi, input logic [7:0] lo);
    dir_row_t row;
    row.core   = core;
    row.tgt    = tgt;
    row.typed  = typed;
    row.res.ok = ok;
    row.res.hi = hi;
    row.res.lo = lo;
    dir_tbl.push_back(row);
  endtask

  task automatic report(input string what, input int expv, input int gotv);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS)
      $display("MISMATCH %s: expected %0d, got %0d at %0t", what, expv, gotv, $realtime);
  endtask

  // Present one item at a falling edge, hold until accepted, log its expectation
  task automatic send_item(input logic [15:0] core, input logic [15:0] tgt,
                           input baud_res_t exp_res);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    core_clock_khz  <= core;
    target_rate_khz <= tgt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    baud_q.push_back(exp_res);
    @(negedge clk);
  endtask

  // Receiver back-pressure
  always @(negedge clk) begin
    out_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
  end

  // Result checker
  always @(posedge clk) begin
    baud_res_t want;
    if (!rst && out_valid && out_ready) begin
      if (baud_q.size() == 0) begin
        report("result with nothing pending, success", 0, success);
      end else begin
        want = baud_q.pop_front();
        if (success !== want.ok)     report("success", want.ok, success);
        if (high_divisor !== want.hi) report("high_divisor", want.hi, high_divisor);
        if (low_divisor !== want.lo)  report("low_divisor", want.lo, low_divisor);
      end
    end
  end

  // Hard stop
  initial begin
    #2_400_000;
    $display("Mismatches found");
    $finish;
  end

  // Stimulus
  initial begin
    logic [15:0] core;
    logic [15:0] tgt;
    logic [31:0] prod;
    baud_res_t   want;
    int          pick;
    int          lo_t;
    int          hi_t;

    rst             = 1'b1;
    in_valid        = 1'b0;
    core_clock_khz  = '0;
    target_rate_khz = '0;
    idle_on         = 1'b1;
    err_cnt         = 0;

    // Directed rows: zero target, out of range, ratio at each class minimum, extremes
    add_row(16'd0,      16'd0,      1'b1, 1'b0, 8'd0, 8'd0);
    add_row(16'd65535,  16'd0,      1'b1, 1'b0, 8'd0, 8'd0);
    add_row(16'd65535,  16'd3401,   1'b1, 1'b0, 8'd0, 8'd0);
    add_row(16'd65535,  16'd65535,  1'b1, 1'b0, 8'd0, 8'd0);
    add_row(16'hAAAA,   16'h5555,   1'b1, 1'b0, 8'd0, 8'd0);
    add_row(16'd0,      16'd100,    1'b1, 1'b0, 8'd0, 8'd0);
    add_row(16'd0,      16'd3400,   1'b1, 1'b0, 8'd0, 8'd0);
    add_row(16'd1200,   16'd100,    1'b1, 1'b0, 8'd0, 8'd0);
    add_row(16'd1300,   16'd100,    1'b1, 1'b1, 8'd1, 8'd1);
    add_row(16'd4800,   16'd400,    1'b1, 1'b0, 8'd0, 8'd0);
    add_row(16'd5200,   16'd400,    1'b1, 1'b1, 8'd1, 8'd1);
    add_row(16'd13999,  16'd1000,   1'b1, 1'b0, 8'd0, 8'd0);
    add_row(16'd14000,  16'd1000,   1'b1, 1'b1, 8'd1, 8'd2);
    add_row(16'd16999,  16'd3400,   1'b1, 1'b0, 8'd0, 8'd0);
    add_row(16'd17000,  16'd3400,   1'b1, 1'b1, 8'd1, 8'd2);
    add_row(16'd65535,  16'd3400,   1'b1, 1'b1, 8'd5, 8'd10);
    // divisor wrap and class edges at full core clock
    add_row(16'd65535,  16'd1,      1'b0, 1'b0, 8'd0, 8'd0);
    add_row(16'd65535,  16'd100,    1'b0, 1'b0, 8'd0, 8'd0);
    add_row(16'd65535,  16'd101,    1'b0, 1'b0, 8'd0, 8'd0);
    add_row(16'd65535,  16'd400,    1'b0, 1'b0, 8'd0, 8'd0);
    add_row(16'd65535,  16'd401,    1'b0, 1'b0, 8'd0, 8'd0);
    add_row(16'd65535,  16'd1000,   1'b0, 1'b0, 8'd0, 8'd0);
    add_row(16'd65535,  16'd1001,   1'b0, 1'b0, 8'd0, 8'd0);
    add_row(16'h5555,   16'h0AAA,   1'b0, 1'b0, 8'd0, 8'd0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tbl[i]) begin
      want = dir_tbl[i].typed ? dir_tbl[i].res : calc_baud(dir_tbl[i].core, dir_tbl[i].tgt);
      send_item(dir_tbl[i].core, dir_tbl[i].tgt, want);
    end

    // Random items, biased toward legal targets and ratios near the class minimum
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 400) idle_on <= 1'b0;
      if (n == 600) idle_on <= 1'b1;
      // let the pipeline empty once with the sender held off
      if (n == 700) begin
        in_valid <= 1'b0;
        while (baud_q.size() != 0) @(negedge clk);
      end

      pick = $urandom_range(99);
      if (pick < 5) begin
        tgt = 16'd0;
      end else if (pick < 15) begin
        tgt = 16'($urandom);
      end else begin
        case ($urandom_range(3))
          0:       begin lo_t = 1;    hi_t = 100;  end
          1:       begin lo_t = 101;  hi_t = 400;  end
          2:       begin lo_t = 401;  hi_t = 1000; end
          default: begin lo_t = 1001; hi_t = 3400; end
        endcase
        tgt = 16'($urandom_range(hi_t, lo_t));
      end

      pick = $urandom_range(99);
      if (pick < 50 || tgt == 16'd0) begin
        core = 16'($urandom);
      end else if (pick < 80) begin
        prod = 32'(tgt) * 32'($urandom_range(20, 4)) + 32'($urandom_range(tgt - 1, 0));
        core = (prod > 32'd65535) ? 16'($urandom) : prod[15:0];
      end else begin
        core = 16'($urandom_range(2000, 0));
      end

      send_item(core, tgt, calc_baud(core, tgt));
    end
    in_valid <= 1'b0;

    while (baud_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/i2cbd_pkg.sv
rtl/i2c_baud_divider_calc.sv
dv/tb_top.sv
